### design/cross_u_statistic_l4_cumulative_top_defines.svh
// Assertion macros used by the cross U-statistic top module.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef CROSS_U_STATISTIC_L4_CUMULATIVE_TOP_DEFINES_SVH
`define CROSS_U_STATISTIC_L4_CUMULATIVE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CUSL4C_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define CUSL4C_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/cusl4c_pkg.sv
// Package for the cross U-statistic block: sizes, types, register indexes, states.
// No dependencies.
`timescale 1ns / 1ps

package cusl4c_pkg;

	localparam int MAX_COLUMNS = 16;
	localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CNT_W = $clog2(MAX_COLUMNS + 32);

	localparam int SAMPLE_W = 8;
	localparam int CUM_W = 55;
	localparam int ROW_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 6;
	localparam int COLS_CFG_W = 5;

	localparam int P1_W = 14;
	localparam int P2_W = 21;
	localparam int P3_W = 28;
	localparam int WGT_W = 38;
	localparam int DOT_W = 49;
	localparam int ACC_W = 48;
	localparam int MUL_A_W = 41;
	localparam int MUL_B_W = 22;
	localparam int INV_LO_W = 21;

	// Inverse of 3 modulo 2^WGT_W: exact division by 3 becomes a multiply.
	localparam logic [WGT_W-1:0] INV3 = 38'h2A_AAAA_AAAB;

	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_USED = 2'd1;

	typedef logic [COL_W-1:0] col_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [P1_W-1:0] p1_t;
	typedef logic signed [P2_W-1:0] p2_t;
	typedef logic signed [P3_W-1:0] p3_t;
	typedef logic signed [WGT_W-1:0] wgt_t;
	typedef logic signed [DOT_W-1:0] dot_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [CUM_W-1:0] cum_t;
	typedef logic signed [MUL_A_W-1:0] mula_t;
	typedef logic signed [MUL_B_W-1:0] mulb_t;
	typedef logic signed [MUL_A_W+MUL_B_W-1:0] prod_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_CUBE,
		ST_DOT,
		ST_ADV,
		ST_EMIT,
		ST_E_SQ,
		ST_E_CUBE,
		ST_E_P12,
		ST_E_LO,
		ST_E_HI
	} state_t;

endpackage

### design/cusl4c_ifs.sv
// Handshake channel interfaces: sample input, result output, register writes.
// Depends on cusl4c_pkg.
`timescale 1ns / 1ps

interface cusl4c_in_if;
	logic valid;
	logic ready;
	logic signed [cusl4c_pkg::SAMPLE_W-1:0] sample;
	logic last_sample;
	modport source(output valid, sample, last_sample, input ready);
	modport sink(input valid, sample, last_sample, output ready);
endinterface

interface cusl4c_out_if;
	logic valid;
	logic ready;
	logic signed [cusl4c_pkg::CUM_W-1:0] cumulative;
	logic [cusl4c_pkg::ROW_W-1:0] row_count;
	logic final_row;
	modport source(output valid, cumulative, row_count, final_row, input ready);
	modport sink(input valid, cumulative, row_count, final_row, output ready);
endinterface

interface cusl4c_cfg_if;
	logic valid;
	logic ready;
	logic [cusl4c_pkg::CFG_IDX_W-1:0] index;
	logic [cusl4c_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### design/cross_u_statistic_l4_cumulative_top.sv
// Channel   | dir | payload                                | request taken when
// samples   | in  | sample[7:0] signed, last_sample        | valid && ready
// results   | out | cumulative[54:0], row_count[5:0], final| valid && ready
// cfg       | in  | index[1:0] (0 split_rows, 1 cols), data| valid && ready (always ready)
//
// Steps: a sample is accepted, takes two multiplies before the split or one after
// it, then a row step, plus an emit step at a row end after the split.
// The row that reaches the split then forms the weights for all 16 columns; one
// shared signed 41x22 multiplier serves all of it.
// Reset: arst_n clears control, power-sum valid bits and registers to defaults.
// Stalls: a waiting result holds in the output register while the next sample
// is taken; only a second result with the first still pending holds the block.
// Depends on cusl4c_pkg, cusl4c_ifs and the assertion macro header.
`timescale 1ns / 1ps
`include "cross_u_statistic_l4_cumulative_top_defines.svh"

module cross_u_statistic_l4_cumulative_top (
	input logic clk,
	input logic arst_n,
	cusl4c_in_if.sink samples,
	cusl4c_out_if.source results,
	cusl4c_cfg_if.sink cfg
);

	// Configuration registers
	cusl4c_pkg::row_t split_q;
	logic [cusl4c_pkg::COLS_CFG_W-1:0] cols_q;

	// Sequencer and matrix-level state
	cusl4c_pkg::state_t state_q, state_d;
	cusl4c_pkg::col_t col_q;
	cusl4c_pkg::col_t ecol_q;
	cusl4c_pkg::row_t row_q;
	cusl4c_pkg::dot_t dot_q;
	cusl4c_pkg::cum_t total_q;
	logic past_q;
	logic [cusl4c_pkg::MAX_COLUMNS-1:0] pv_q;

	// Per-column stores
	cusl4c_pkg::p1_t p1_q [cusl4c_pkg::MAX_COLUMNS];
	cusl4c_pkg::p2_t p2_q [cusl4c_pkg::MAX_COLUMNS];
	cusl4c_pkg::p3_t p3_q [cusl4c_pkg::MAX_COLUMNS];
	cusl4c_pkg::wgt_t w_q [cusl4c_pkg::MAX_COLUMNS];

	// Work registers
	cusl4c_pkg::sample_t x_q;
	logic last_q;
	cusl4c_pkg::wgt_t m_q;
	cusl4c_pkg::acc_t acc_q;

	// Output register
	logic out_valid_q;
	cusl4c_pkg::cum_t out_cum_q;
	cusl4c_pkg::row_t out_row_q;
	logic out_final_q;

	// Shared multiplier
	cusl4c_pkg::mula_t mul_a;
	cusl4c_pkg::mulb_t mul_b;
	cusl4c_pkg::prod_t prod;

	// Derived control
	cusl4c_pkg::col_t rd_idx;
	cusl4c_pkg::p1_t p1_rd;
	cusl4c_pkg::p2_t p2_rd;
	cusl4c_pkg::p3_t p3_rd;
	cusl4c_pkg::cnt_t cols_eff;
	cusl4c_pkg::row_t split_eff;
	cusl4c_pkg::cnt_t col_inc;
	cusl4c_pkg::row_t row_inc;
	logic wrap;
	logic row_end;
	logic split_hit;
	logic emit_go;
	logic accept;
	logic ecol_last;

	assign samples.ready = (state_q == cusl4c_pkg::ST_IDLE);
	assign accept = samples.valid && samples.ready;
	assign cfg.ready = 1'b1;

	assign results.valid = out_valid_q;
	assign results.cumulative = out_cum_q;
	assign results.row_count = out_row_q;
	assign results.final_row = out_final_q;

	// Sweep reads the weight column, otherwise the current sample column
	assign rd_idx = (state_q == cusl4c_pkg::ST_E_SQ || state_q == cusl4c_pkg::ST_E_CUBE ||
		state_q == cusl4c_pkg::ST_E_P12) ? ecol_q : col_q;
	// A column not touched since the last clear reads as zero
	assign p1_rd = pv_q[rd_idx] ? p1_q[rd_idx] : '0;
	assign p2_rd = pv_q[rd_idx] ? p2_q[rd_idx] : '0;
	assign p3_rd = pv_q[rd_idx] ? p3_q[rd_idx] : '0;

	// Clamp the registers to their usable ranges
	always_comb begin
		if (cols_q == '0) begin
			cols_eff = cusl4c_pkg::cnt_t'(1);
		end else if (cusl4c_pkg::cnt_t'(cols_q) > cusl4c_pkg::cnt_t'(cusl4c_pkg::MAX_COLUMNS)) begin
			cols_eff = cusl4c_pkg::cnt_t'(cusl4c_pkg::MAX_COLUMNS);
		end else begin
			cols_eff = cusl4c_pkg::cnt_t'(cols_q);
		end
	end
	assign split_eff = (split_q == '0) ? cusl4c_pkg::row_t'(1) : split_q;

	assign col_inc = cusl4c_pkg::cnt_t'(col_q) + cusl4c_pkg::cnt_t'(1);
	assign wrap = (col_inc >= cols_eff);
	assign row_end = wrap || last_q;
	assign row_inc = (row_q != '1) ? row_q + cusl4c_pkg::row_t'(1) : row_q;
	assign split_hit = (row_inc >= split_eff);
	assign emit_go = !out_valid_q || results.ready;
	assign ecol_last = (ecol_q == cusl4c_pkg::col_t'(cusl4c_pkg::MAX_COLUMNS - 1));

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			cusl4c_pkg::ST_SQ: begin
				mul_a = cusl4c_pkg::mula_t'(x_q);
				mul_b = cusl4c_pkg::mulb_t'(x_q);
			end
			cusl4c_pkg::ST_CUBE: begin
				mul_a = cusl4c_pkg::mula_t'(m_q);
				mul_b = cusl4c_pkg::mulb_t'(x_q);
			end
			cusl4c_pkg::ST_DOT: begin
				mul_a = cusl4c_pkg::mula_t'(w_q[col_q]);
				mul_b = cusl4c_pkg::mulb_t'(x_q);
			end
			cusl4c_pkg::ST_E_SQ: begin
				mul_a = cusl4c_pkg::mula_t'(p1_rd);
				mul_b = cusl4c_pkg::mulb_t'(p1_rd);
			end
			cusl4c_pkg::ST_E_CUBE: begin
				mul_a = cusl4c_pkg::mula_t'(m_q);
				mul_b = cusl4c_pkg::mulb_t'(p1_rd);
			end
			cusl4c_pkg::ST_E_P12: begin
				mul_a = cusl4c_pkg::mula_t'(p2_rd);
				mul_b = cusl4c_pkg::mulb_t'(p1_rd);
			end
			cusl4c_pkg::ST_E_LO: begin
				mul_a = cusl4c_pkg::mula_t'({1'b0, acc_q[cusl4c_pkg::WGT_W:1]});
				mul_b = cusl4c_pkg::mulb_t'({1'b0, cusl4c_pkg::INV3[cusl4c_pkg::INV_LO_W-1:0]});
			end
			cusl4c_pkg::ST_E_HI: begin
				mul_a = cusl4c_pkg::mula_t'({1'b0, acc_q[cusl4c_pkg::WGT_W:1]});
				mul_b = cusl4c_pkg::mulb_t'({1'b0,
					cusl4c_pkg::INV3[cusl4c_pkg::WGT_W-1:cusl4c_pkg::INV_LO_W]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cusl4c_pkg::ST_IDLE: begin
				if (samples.valid) begin
					state_d = past_q ? cusl4c_pkg::ST_DOT : cusl4c_pkg::ST_SQ;
				end
			end
			cusl4c_pkg::ST_SQ: state_d = cusl4c_pkg::ST_CUBE;
			cusl4c_pkg::ST_CUBE: state_d = cusl4c_pkg::ST_ADV;
			cusl4c_pkg::ST_DOT: state_d = cusl4c_pkg::ST_ADV;
			cusl4c_pkg::ST_ADV: begin
				if (!row_end) begin
					state_d = cusl4c_pkg::ST_IDLE;
				end else if (past_q) begin
					state_d = cusl4c_pkg::ST_EMIT;
				end else if (!last_q && split_hit) begin
					state_d = cusl4c_pkg::ST_E_SQ;
				end else begin
					state_d = cusl4c_pkg::ST_IDLE;
				end
			end
			cusl4c_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = cusl4c_pkg::ST_IDLE;
				end
			end
			cusl4c_pkg::ST_E_SQ: state_d = cusl4c_pkg::ST_E_CUBE;
			cusl4c_pkg::ST_E_CUBE: state_d = cusl4c_pkg::ST_E_P12;
			cusl4c_pkg::ST_E_P12: state_d = cusl4c_pkg::ST_E_LO;
			cusl4c_pkg::ST_E_LO: state_d = cusl4c_pkg::ST_E_HI;
			cusl4c_pkg::ST_E_HI: begin
				state_d = ecol_last ? cusl4c_pkg::ST_IDLE : cusl4c_pkg::ST_E_SQ;
			end
			default: state_d = cusl4c_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cusl4c_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= cusl4c_pkg::row_t'(1);
			cols_q <= cusl4c_pkg::COLS_CFG_W'(16);
		end else if (cfg.valid) begin
			case (cfg.index)
				cusl4c_pkg::REG_SPLIT_ROWS: split_q <= cfg.data[cusl4c_pkg::ROW_W-1:0];
				cusl4c_pkg::REG_COLUMNS_USED: cols_q <= cfg.data[cusl4c_pkg::COLS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Control and matrix state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			ecol_q <= '0;
			row_q <= '0;
			dot_q <= '0;
			total_q <= '0;
			past_q <= 1'b0;
			pv_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result from the emit step, else drop the one taken
			if (state_q == cusl4c_pkg::ST_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				cusl4c_pkg::ST_CUBE: begin
					pv_q[col_q] <= 1'b1;
				end
				cusl4c_pkg::ST_DOT: begin
					dot_q <= dot_q + prod[cusl4c_pkg::DOT_W-1:0];
				end
				cusl4c_pkg::ST_ADV: begin
					if (!row_end) begin
						// advance to the next column of this row
						col_q <= col_inc[cusl4c_pkg::COL_W-1:0];
					end else if (past_q) begin
						// fold the row into the running total; emit next cycle
						col_q <= '0;
						total_q <= total_q + cusl4c_pkg::cum_t'(dot_q);
						dot_q <= '0;
						row_q <= row_inc;
					end else if (last_q) begin
						// matrix ended before the split: drop everything
						col_q <= '0;
						row_q <= '0;
						dot_q <= '0;
						total_q <= '0;
						pv_q <= '0;
					end else begin
						col_q <= '0;
						row_q <= split_hit ? '0 : row_inc;
						ecol_q <= '0;
					end
				end
				cusl4c_pkg::ST_EMIT: begin
					if (emit_go && last_q) begin
						col_q <= '0;
						row_q <= '0;
						dot_q <= '0;
						total_q <= '0;
						past_q <= 1'b0;
						pv_q <= '0;
					end
				end
				cusl4c_pkg::ST_E_HI: begin
					if (ecol_last) begin
						past_q <= 1'b1;
					end else begin
						ecol_q <= ecol_q + cusl4c_pkg::col_t'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload and per-column stores
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= samples.sample;
			last_q <= samples.last_sample;
		end
		case (state_q)
			cusl4c_pkg::ST_SQ: begin
				m_q <= prod[cusl4c_pkg::WGT_W-1:0];
			end
			cusl4c_pkg::ST_CUBE: begin
				// power sums of the current column
				p1_q[col_q] <= p1_rd + cusl4c_pkg::p1_t'(x_q);
				p2_q[col_q] <= p2_rd + m_q[cusl4c_pkg::P2_W-1:0];
				p3_q[col_q] <= p3_rd + prod[cusl4c_pkg::P3_W-1:0];
			end
			cusl4c_pkg::ST_E_SQ: begin
				m_q <= prod[cusl4c_pkg::WGT_W-1:0];
			end
			cusl4c_pkg::ST_E_CUBE: begin
				// p1^3 + 2*p3
				acc_q <= prod[cusl4c_pkg::ACC_W-1:0] + (cusl4c_pkg::acc_t'(p3_rd) <<< 1);
			end
			cusl4c_pkg::ST_E_P12: begin
				// minus 3*p1*p2
				acc_q <= acc_q - prod[cusl4c_pkg::ACC_W-1:0]
					- {prod[cusl4c_pkg::ACC_W-2:0], 1'b0};
			end
			cusl4c_pkg::ST_E_LO: begin
				m_q <= prod[cusl4c_pkg::WGT_W-1:0];
			end
			cusl4c_pkg::ST_E_HI: begin
				// numerator is even and a multiple of 3: halve, then times inverse of 3
				w_q[ecol_q] <= m_q + {prod[cusl4c_pkg::WGT_W-cusl4c_pkg::INV_LO_W-1:0],
					cusl4c_pkg::INV_LO_W'(0)};
			end
			cusl4c_pkg::ST_EMIT: begin
				if (emit_go) begin
					out_cum_q <= total_q;
					out_row_q <= row_q;
					out_final_q <= last_q;
				end
			end
			default: ;
		endcase
	end

	`CUSL4C_ASSERT_IMP(a_emit_src, $rose(out_valid_q), $past(state_q) == cusl4c_pkg::ST_EMIT, "result raised outside emit")
	`CUSL4C_ASSERT_NXT(a_accept_path, accept, (state_q == cusl4c_pkg::ST_SQ && !past_q) || (state_q == cusl4c_pkg::ST_DOT && past_q), "sample took wrong path")
	`CUSL4C_ASSERT_IMP(a_sweep_pre, state_q == cusl4c_pkg::ST_E_SQ, !past_q, "weight sweep after split")
	`CUSL4C_ASSERT_NXT(a_sweep_done, state_q == cusl4c_pkg::ST_E_HI && ecol_last, past_q && state_q == cusl4c_pkg::ST_IDLE, "sweep end did not pass split")

endmodule
